FILE: rtl/itc_pkg.sv
// Shared types and constants for the interval timer channels block.
package itc_pkg;

    // Widths of the item and result fields.
    localparam int CMD_W    = 2;
    localparam int CHAN_W   = 3;
    localparam int DATA_W   = 8;
    localparam int TICKS_W  = 16;
    localparam int COUNT_W  = 16;
    localparam int MASK_W   = 6;
    localparam int LEVELS_W = 6;

    // The widest tick step: 65535 ticks, times four, times two in square mode.
    localparam int STEP_W = 20;

    // Defaults for the top-level parameters.
    localparam int NUM_CHANNELS_DEF = 6;
    localparam int FAST_CHANNEL_DEF = 4;
    localparam int FAST_STEP_DEF    = 4;

    // Mode mask after reset: set bits select square-wave mode.
    localparam logic [MASK_W-1:0] MODE_MASK_RESET = 6'd61;

    // A zero reload value reloads as the full count.
    localparam logic [COUNT_W-1:0] RELOAD_FULL = 16'hffff;

    // Commands carried by each input beat.
    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE   = 2'd0,
        CMD_CONTROL = 2'd1,
        CMD_READ    = 2'd2,
        CMD_TICK    = 2'd3
    } cmd_e_t;

    // Read/load mode field of a control word.
    typedef enum logic [1:0] {
        RL_LATCH = 2'd0,
        RL_LOW   = 2'd1,
        RL_HIGH  = 2'd2,
        RL_BOTH  = 2'd3
    } rl_e_t;

    // One registered input item.
    typedef struct packed {
        cmd_e_t              cmd;
        logic [CHAN_W-1:0]   channel;
        logic [DATA_W-1:0]   data_byte;
        logic [TICKS_W-1:0]  ticks;
    } item_t;

endpackage

FILE: rtl/itc_channel.sv
// One down-counter channel: byte access, latching and tick batches.
module itc_channel
    import itc_pkg::*;
#(
    parameter int          CHAN_IDX  = 0,
    parameter int          STEP_MULT = 1,
    parameter logic        RUN_RESET = 1'b0
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_square,
    input  logic               square,
    input  logic               fire,
    input  item_t              item,
    output logic [DATA_W-1:0]  rd_data,
    output logic               level_next
);

    logic [COUNT_W-1:0] reload_reg, reload_next;
    logic [COUNT_W-1:0] count_reg,  count_next;
    logic [COUNT_W-1:0] latch_reg,  latch_next;
    logic               held_reg,   held_next;
    logic               low_reg,    low_next;
    rl_e_t              lm_reg,     lm_next;
    logic               level_reg;
    logic               running_reg, running_next;

    logic               sel;
    logic [COUNT_W-1:0] src;
    logic [COUNT_W-1:0] wr_value;
    logic [STEP_W-1:0]  prod;
    logic [STEP_W-1:0]  step;
    rl_e_t              rl;

    assign sel = (item.channel == CHAN_W'(CHAN_IDX));
    assign rl  = rl_e_t'(item.data_byte[5:4]);

    // Byte returned by a read: latched value while held, else the live count.
    assign src     = held_reg ? latch_reg : count_reg;
    assign rd_data = (sel && item.cmd == CMD_READ)
                   ? (low_reg ? src[7:0] : src[15:8]) : '0;

    // Tick step for this channel, doubled in square-wave mode.
    assign prod = STEP_W'(item.ticks) * STEP_W'(STEP_MULT);
    assign step = square ? {prod[STEP_W-2:0], 1'b0} : prod;

    // New reload value on a count byte write.
    always_comb
    begin
        if (low_reg)
        begin
            wr_value = {reload_reg[15:8], item.data_byte};
            if (square)
            begin
                wr_value = wr_value + COUNT_W'(item.data_byte[0]);
            end
        end
        else
        begin
            wr_value = {item.data_byte, reload_reg[7:0]};
        end
    end

    // Next state for the command in flight.
    always_comb
    begin
        reload_next  = reload_reg;
        count_next   = count_reg;
        latch_next   = latch_reg;
        held_next    = held_reg;
        low_next     = low_reg;
        lm_next      = lm_reg;
        level_next   = level_reg;
        running_next = running_reg;
        if (fire)
        begin
            unique case (item.cmd)
                CMD_WRITE:
                begin
                    if (sel)
                    begin
                        if (!square)
                        begin
                            running_next = low_reg ? (lm_reg == RL_LOW) : 1'b1;
                        end
                        level_next  = square;
                        reload_next = wr_value;
                        count_next  = wr_value;
                        if (lm_reg == RL_BOTH)
                        begin
                            low_next = !low_reg;
                        end
                    end
                end
                CMD_CONTROL:
                begin
                    if (sel)
                    begin
                        if (rl == RL_LATCH)
                        begin
                            if (!held_reg)
                            begin
                                held_next  = 1'b1;
                                latch_next = count_reg;
                            end
                        end
                        else
                        begin
                            lm_next  = rl;
                            low_next = (rl != RL_HIGH);
                        end
                    end
                end
                CMD_READ:
                begin
                    if (sel)
                    begin
                        if (!low_reg)
                        begin
                            held_next = 1'b0;
                        end
                        if (lm_reg == RL_BOTH)
                        begin
                            low_next = !low_reg;
                        end
                    end
                end
                CMD_TICK:
                begin
                    if (running_reg)
                    begin
                        if (STEP_W'(count_reg) <= step)
                        begin
                            level_next = square ? !level_reg : 1'b1;
                            count_next = (reload_reg != '0) ? reload_reg : RELOAD_FULL;
                        end
                        else
                        begin
                            count_next = count_reg - step[COUNT_W-1:0];
                        end
                    end
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
        // A mode change restarts the running flag from the new mode.
        if (cfg_we)
        begin
            running_next = cfg_square;
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reload_reg  <= '0;
            count_reg   <= '0;
            latch_reg   <= '0;
            held_reg    <= 1'b0;
            low_reg     <= 1'b1;
            lm_reg      <= RL_LOW;
            level_reg   <= 1'b0;
            running_reg <= RUN_RESET;
        end
        else
        begin
            reload_reg  <= reload_next;
            count_reg   <= count_next;
            latch_reg   <= latch_next;
            held_reg    <= held_next;
            low_reg     <= low_next;
            lm_reg      <= lm_next;
            level_reg   <= level_next;
            running_reg <= running_next;
        end
    end

endmodule

FILE: rtl/interval_timer_channels_core.sv
// Top level of the interval timer channels block: stream stages and channel array.
//
// Input channel (s_*): one beat carries one command. s_tuser holds cmd and the
// channel number; s_tdata holds the count or control byte and the tick count.
// Commands write a count byte, write a control word, read a count byte, or
// apply a batch of ticks to every running channel at once.
// Output channel (m_*): one beat per input beat, in order, with the byte read
// (zero for other commands) and the output level of every channel afterwards.
// The mode mask is written through cfg_we and cfg_wdata; the user must write it
// only while the block is idle, which the block itself does not enforce.
// An accepted input beat passes the input register, a single pass of per-channel
// logic and the result register. Throughput is one beat per cycle while the
// receiver does not stall. If the receiver stalls, the result register holds
// and the input register fills; s_tready falls only when both are occupied.
// After reset every counter is zero, all channels expect a low byte first,
// and the square-wave channels of the reset mode mask are running.
module interval_timer_channels_core
    import itc_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
    parameter int FAST_CHANNEL = FAST_CHANNEL_DEF,
    parameter int FAST_STEP    = FAST_STEP_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    // Configuration: mode mask.
    input  logic               cfg_we,
    input  logic [MASK_W-1:0]  cfg_wdata,
    // Input stream.
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [23:0]        s_tdata,   // data_byte[7:0], ticks[23:8]
    input  logic [4:0]         s_tuser,   // cmd[1:0], channel[4:2]
    // Output stream.
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [15:0]        m_tdata    // read_data[7:0], out_levels[13:8], zero[15:14]
);

    logic [MASK_W-1:0]   mask_reg;
    logic                in_valid_reg, in_valid_next;
    item_t               item_reg;
    logic                out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]   rd_reg, rd_next;
    logic [LEVELS_W-1:0] levels_reg, levels_next;
    logic                fire;

    logic [DATA_W-1:0]   rd_all [NUM_CHANNELS];
    logic                level_all [NUM_CHANNELS];

    // The item in the input register is processed when the result register frees.
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    // Mode mask register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= MODE_MASK_RESET;
        end
        else if (cfg_we)
        begin
            mask_reg <= cfg_wdata;
        end
    end

    // Input register.
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.cmd       <= cmd_e_t'(s_tuser[1:0]);
            item_reg.channel   <= s_tuser[4:2];
            item_reg.data_byte <= s_tdata[7:0];
            item_reg.ticks     <= s_tdata[23:8];
        end
    end

    // Channel array.
    for (genvar c = 0; c < NUM_CHANNELS; c++)
    begin : g_chan
        logic square;
        logic cfg_square;
        if (c < MASK_W)
        begin : g_mode
            assign square     = mask_reg[c];
            assign cfg_square = cfg_wdata[c];
        end
        else
        begin : g_fixed
            assign square     = 1'b0;
            assign cfg_square = 1'b0;
        end

        itc_channel #(
            .CHAN_IDX  (c),
            .STEP_MULT ((c == FAST_CHANNEL) ? FAST_STEP : 1),
            .RUN_RESET ((c < MASK_W) ? MODE_MASK_RESET[c % MASK_W] : 1'b0)
        ) u_channel (
            .clk        (clk),
            .rst_n      (rst_n),
            .cfg_we     (cfg_we),
            .cfg_square (cfg_square),
            .square     (square),
            .fire       (fire),
            .item       (item_reg),
            .rd_data    (rd_all[c]),
            .level_next (level_all[c])
        );
    end

    // Read byte: only the addressed channel drives a non-zero value.
    always_comb
    begin
        rd_next = '0;
        for (int c = 0; c < NUM_CHANNELS; c++)
        begin
            rd_next = rd_next | rd_all[c];
        end
    end

    // Output levels after the item, one bit per channel.
    for (genvar b = 0; b < LEVELS_W; b++)
    begin : g_level
        if (b < NUM_CHANNELS)
        begin : g_used
            assign levels_next[b] = level_all[b];
        end
        else
        begin : g_unused
            assign levels_next[b] = 1'b0;
        end
    end

    // Result register.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            rd_reg     <= rd_next;
            levels_reg <= levels_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, levels_reg, rd_reg};

endmodule

FILE: verif/tb_interval_timer_channels_core.sv
// Self-checking testbench for the six-channel interval timer core.
`timescale 1ns / 100ps

module tb_interval_timer_channels_core;
    import itc_pkg::*;

    // One expected output beat.
    typedef struct {
        logic [DATA_W-1:0]   read_data;
        logic [LEVELS_W-1:0] out_levels;
    } reply_t;

    // Predicts the reply to every accepted command and checks the replies that come out.
    class timer_predictor;
        logic [MASK_W-1:0]  square_mask;
        logic [COUNT_W-1:0] reload_val [NUM_CHANNELS_DEF];
        logic [COUNT_W-1:0] count_val [NUM_CHANNELS_DEF];
        logic [COUNT_W-1:0] latch_val [NUM_CHANNELS_DEF];
        bit                 latch_held [NUM_CHANNELS_DEF];
        bit                 low_next [NUM_CHANNELS_DEF];
        bit                 level [NUM_CHANNELS_DEF];
        bit                 running [NUM_CHANNELS_DEF];
        rl_e_t              load_mode [NUM_CHANNELS_DEF];
        reply_t             pending_replies [$];
        int unsigned        failures;

        function new();
            square_mask = MODE_MASK_RESET;
            failures    = 0;
            for (int c = 0; c < NUM_CHANNELS_DEF; c++)
            begin
                reload_val[c] = '0;
                count_val[c]  = '0;
                latch_val[c]  = '0;
                latch_held[c] = 1'b0;
                low_next[c]   = 1'b1;
                load_mode[c]  = RL_LOW;
                level[c]      = 1'b0;
                running[c]    = square_mask[c];
            end
        endfunction

        // A mode mask write restarts every square-wave channel and stops the others.
        function void set_mode_mask(logic [MASK_W-1:0] mask);
            square_mask = mask;
            for (int c = 0; c < NUM_CHANNELS_DEF; c++)
                running[c] = mask[c];
        endfunction

        function void load_count_byte(int c, logic [DATA_W-1:0] data_b);
            logic [COUNT_W-1:0] v;
            bit                 sq;
            v  = reload_val[c];
            sq = square_mask[c];
            if (low_next[c])
            begin
                v[7:0] = data_b;
                if (!sq)
                    running[c] = (load_mode[c] == RL_LOW);
            end
            else
            begin
                v[15:8] = data_b;
                if (!sq)
                    running[c] = 1'b1;
            end
            // Square-wave channels round an odd low byte up to even.
            if (sq)
            begin
                level[c] = 1'b1;
                if (low_next[c])
                    v = v + COUNT_W'(data_b[0]);
            end
            else
                level[c] = 1'b0;
            reload_val[c] = v;
            count_val[c]  = v;
            if (load_mode[c] == RL_BOTH)
                low_next[c] = !low_next[c];
        endfunction

        function void apply_control(int c, logic [DATA_W-1:0] data_b);
            rl_e_t rl;
            rl = rl_e_t'(data_b[5:4]);
            if (rl == RL_LATCH)
            begin
                // A second latch keeps the value already held.
                if (!latch_held[c])
                begin
                    latch_held[c] = 1'b1;
                    latch_val[c]  = count_val[c];
                end
            end
            else
            begin
                load_mode[c] = rl;
                low_next[c]  = (rl != RL_HIGH);
            end
        endfunction

        function logic [DATA_W-1:0] read_count_byte(int c);
            logic [COUNT_W-1:0] src;
            logic [DATA_W-1:0]  data_b;
            src = latch_held[c] ? latch_val[c] : count_val[c];
            if (low_next[c])
                data_b = src[7:0];
            else
            begin
                data_b        = src[15:8];
                latch_held[c] = 1'b0;
            end
            if (load_mode[c] == RL_BOTH)
                low_next[c] = !low_next[c];
            return data_b;
        endfunction

        // At most one reload per batch; a zero reload value reloads as the full count.
        function void advance_ticks(logic [TICKS_W-1:0] ticks);
            int unsigned step;
            for (int c = 0; c < NUM_CHANNELS_DEF; c++)
            begin
                if (running[c])
                begin
                    step = 32'(ticks);
                    if (c == FAST_CHANNEL_DEF)
                        step = step * FAST_STEP_DEF;
                    if (square_mask[c])
                        step = step * 2;
                    if (int'(count_val[c]) <= step)
                    begin
                        level[c]     = square_mask[c] ? !level[c] : 1'b1;
                        count_val[c] = (reload_val[c] != '0) ? reload_val[c] : RELOAD_FULL;
                    end
                    else
                        count_val[c] = count_val[c] - COUNT_W'(step);
                end
            end
        endfunction

        function void take_command(cmd_e_t cmd, logic [CHAN_W-1:0] chan,
                                   logic [DATA_W-1:0] data_b, logic [TICKS_W-1:0] ticks);
            reply_t r;
            bit     in_range;
            in_range    = (chan < NUM_CHANNELS_DEF);
            r.read_data = '0;
            case (cmd)
                CMD_WRITE:   if (in_range) load_count_byte(int'(chan), data_b);
                CMD_CONTROL: if (in_range) apply_control(int'(chan), data_b);
                CMD_READ:    if (in_range) r.read_data = read_count_byte(int'(chan));
                default:     advance_ticks(ticks);
            endcase
            for (int c = 0; c < LEVELS_W; c++)
                r.out_levels[c] = (c < NUM_CHANNELS_DEF) ? level[c] : 1'b0;
            pending_replies.insert(pending_replies.size(), r);
        endfunction

        function void check_reply(logic [15:0] tdata);
            reply_t r;
            if (pending_replies.size() == 0)
            begin
                $error("output beat with no reply expected: %0h", tdata);
                failures++;
                return;
            end
            r = pending_replies.pop_front();
            if (tdata[7:0] !== r.read_data)
            begin
                $error("read_data: expected %0h, got %0h", r.read_data, tdata[7:0]);
                failures++;
            end
            if (tdata[13:8] !== r.out_levels)
            begin
                $error("out_levels: expected %0h, got %0h", r.out_levels, tdata[13:8]);
                failures++;
            end
        endfunction
    endclass

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [MASK_W-1:0] cfg_wdata = '0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [23:0]       s_tdata   = '0;   // data_byte[7:0], ticks[23:8]
    logic [4:0]        s_tuser   = '0;   // cmd[1:0], channel[4:2]
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [15:0]       m_tdata;          // read_data[7:0], out_levels[13:8], zero[15:14]

    int unsigned    send_idle_pct = 0;
    int unsigned    recv_idle_pct = 0;
    int unsigned    beats_sent    = 0;
    timer_predictor model         = new();

    interval_timer_channels_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // 4 ns clock.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Receiver back-pressure.
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    // Watch both streams; values seen here are those from before the edge.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            model.check_reply(m_tdata);
        if (rst_n && s_tvalid && s_tready)
            model.take_command(cmd_e_t'(s_tuser[1:0]), s_tuser[4:2], s_tdata[7:0],
                               s_tdata[23:8]);
    end

    // Offer one command beat, after a random gap, and wait until it is taken.
    task automatic send_beat(cmd_e_t cmd, logic [CHAN_W-1:0] chan,
                             logic [DATA_W-1:0] data_b, logic [TICKS_W-1:0] ticks);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {chan, cmd};
        s_tdata  <= {ticks, data_b};
        do
            @(posedge clk);
        while (!s_tready);
        beats_sent++;
    endtask

    // Hold off the sender until every reply has come out.
    task automatic drain_replies();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (model.pending_replies.size() != 0);
    endtask

    // Mode mask write, only with the block idle.
    task automatic write_mode_mask(logic [MASK_W-1:0] mask);
        drain_replies();
        repeat (3) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= mask;
        @(posedge clk);
        cfg_we <= 1'b0;
        model.set_mode_mask(mask);
    endtask

    function automatic logic [CHAN_W-1:0] pick_channel();
        if ($urandom_range(9) == 0)
            return CHAN_W'($urandom_range(NUM_CHANNELS_DEF, 7));
        return CHAN_W'($urandom_range(NUM_CHANNELS_DEF - 1));
    endfunction

    function automatic logic [TICKS_W-1:0] pick_ticks();
        int unsigned sel;
        sel = $urandom_range(9);
        if (sel < 4)
            return TICKS_W'($urandom_range(8));
        if (sel < 7)
            return TICKS_W'($urandom_range(300));
        if (sel < 9)
            return TICKS_W'($urandom_range(5000));
        return TICKS_W'($urandom_range(16'hffff));
    endfunction

    // Mostly well-formed programming, latch/read and tick sequences, some noise.
    task automatic run_random(int unsigned target);
        int unsigned       kind;
        int unsigned       n;
        logic [CHAN_W-1:0] chan;
        logic [DATA_W-1:0] cw;
        rl_e_t             rl;
        while (beats_sent < target)
        begin
            kind = $urandom_range(99);
            chan = pick_channel();
            if (kind < 25)
            begin
                rl      = rl_e_t'($urandom_range(1, 3));
                cw      = DATA_W'($urandom_range(255));
                cw[5:4] = rl;
                send_beat(CMD_CONTROL, chan, cw, TICKS_W'($urandom_range(16'hffff)));
                send_beat(CMD_WRITE, chan, DATA_W'($urandom_range(255)), '0);
                if (rl == RL_BOTH)
                    send_beat(CMD_WRITE, chan,
                              ($urandom_range(9) < 6) ? '0 : DATA_W'($urandom_range(255)), '0);
            end
            else if (kind < 45)
            begin
                if ($urandom_range(1))
                begin
                    cw      = DATA_W'($urandom_range(255));
                    cw[5:4] = RL_LATCH;
                    send_beat(CMD_CONTROL, chan, cw, '0);
                end
                n = $urandom_range(1, 2);
                repeat (n) send_beat(CMD_READ, chan, DATA_W'($urandom_range(255)), '0);
            end
            else if (kind < 80)
            begin
                n = $urandom_range(1, 3);
                repeat (n) send_beat(CMD_TICK, CHAN_W'($urandom_range(7)),
                                     DATA_W'($urandom_range(255)), pick_ticks());
            end
            else
                send_beat(cmd_e_t'($urandom_range(3)), CHAN_W'($urandom_range(7)),
                          DATA_W'($urandom_range(255)), TICKS_W'($urandom_range(16'hffff)));
            if ($urandom_range(99) == 0)
                drain_replies();
        end
    endtask

    // Run limit.
    initial
    begin
        #2ms;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        logic [MASK_W-1:0] masks [6];
        masks[0] = MODE_MASK_RESET;
        masks[1] = '0;
        masks[2] = '1;
        masks[3] = MASK_W'($urandom_range(63));
        masks[4] = MASK_W'($urandom_range(63));
        masks[5] = MODE_MASK_RESET;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset mode mask: channel 1 one-shot, the rest square.
        send_beat(CMD_TICK, 3'd0, 8'h00, 16'd0);
        send_beat(CMD_CONTROL, 3'd1, {2'b00, RL_BOTH, 4'h0}, 16'd0);
        send_beat(CMD_WRITE, 3'd1, 8'h05, 16'd0);
        send_beat(CMD_WRITE, 3'd1, 8'h00, 16'd0);
        send_beat(CMD_TICK, 3'd0, 8'h00, 16'd5);
        send_beat(CMD_CONTROL, 3'd0, {2'b00, RL_LOW, 4'h1}, 16'd0);
        send_beat(CMD_WRITE, 3'd0, 8'hff, 16'd0);
        send_beat(CMD_CONTROL, 3'd2, {2'b00, RL_HIGH, 4'h0}, 16'd0);
        send_beat(CMD_WRITE, 3'd2, 8'hff, 16'd0);
        send_beat(CMD_CONTROL, 3'd3, {2'b00, RL_BOTH, 4'h0}, 16'd0);
        send_beat(CMD_WRITE, 3'd3, 8'h01, 16'd0);
        send_beat(CMD_WRITE, 3'd3, 8'h00, 16'd0);
        send_beat(CMD_CONTROL, 3'd3, {2'b00, RL_LATCH, 4'h0}, 16'd0);
        send_beat(CMD_TICK, 3'd0, 8'h00, 16'd1);
        send_beat(CMD_CONTROL, 3'd3, {2'b11, RL_LATCH, 4'h0}, 16'd0);
        send_beat(CMD_READ, 3'd3, 8'h00, 16'd0);
        send_beat(CMD_READ, 3'd3, 8'h00, 16'd0);
        send_beat(CMD_CONTROL, 3'd4, {2'b00, RL_BOTH, 4'h0}, 16'd0);
        send_beat(CMD_WRITE, 3'd4, 8'h10, 16'd0);
        send_beat(CMD_WRITE, 3'd4, 8'h00, 16'd0);
        send_beat(CMD_TICK, 3'd0, 8'h00, 16'd3);
        send_beat(CMD_READ, 3'd7, 8'h00, 16'd0);
        send_beat(CMD_WRITE, 3'd6, 8'haa, 16'd0);
        send_beat(CMD_CONTROL, 3'd7, 8'hff, 16'hffff);
        send_beat(CMD_TICK, 3'd7, 8'hff, 16'hffff);

        // Random part in six segments, idling patterns changing every two.
        for (int seg = 0; seg < 6; seg++)
        begin
            if (seg > 0)
                write_mode_mask(masks[seg]);
            if (seg < 2)
            begin
                send_idle_pct = 34;
                recv_idle_pct = 82;
            end
            else if (seg < 4)
            begin
                send_idle_pct = 82;
                recv_idle_pct = 34;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            run_random(25 + (seg + 1) * 288);
        end

        // Let the last replies come out, then look for stray beats.
        drain_replies();
        repeat (20) @(posedge clk);
        if (model.failures == 0 && model.pending_replies.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: interval_timer_channels_core.f
rtl/itc_pkg.sv
rtl/itc_channel.sv
rtl/interval_timer_channels_core.sv
verif/tb_interval_timer_channels_core.sv
